// ===== rtl/rsrl_pkg.sv =====
// Shared types, codes and helpers for the restart supervisor with rate limit.
// No dependencies; every other file imports this package.
package rsrl_pkg;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_RESTART = 3'd2;
  localparam logic [2:0] ACT_FIXPORT = 3'd3;
  localparam logic [2:0] ACT_FAULT   = 3'd4;
  localparam logic [2:0] ACT_SOFTFIX = 3'd5;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_SUCCESS   = 3'd1;
  localparam logic [2:0] ST_COOLDOWN  = 3'd2;
  localparam logic [2:0] ST_RATELIMIT = 3'd3;
  localparam logic [2:0] ST_START     = 3'd4;
  localparam logic [2:0] ST_RESTART   = 3'd5;
  localparam logic [2:0] ST_FIXPORT   = 3'd6;
  localparam logic [2:0] ST_FIXFAULT  = 3'd7;

  localparam logic [2:0] CFG_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_HOLD      = 3'd2;
  localparam logic [2:0] CFG_COOLDOWN  = 3'd3;
  localparam logic [2:0] CFG_MAX       = 3'd4;
  localparam logic [2:0] CFG_WINDOW    = 3'd5;

  localparam logic [15:0] DFLT_THRESHOLD = 16'd3;
  localparam logic [15:0] DFLT_HOLD      = 16'd30;
  localparam logic [15:0] DFLT_COOLDOWN  = 16'd60;
  localparam logic [7:0]  DFLT_MAX       = 8'd5;
  localparam logic [15:0] DFLT_WINDOW    = 16'd600;

  typedef struct packed {
    logic        enable;
    logic [15:0] threshold;
    logic [15:0] hold;
    logic [15:0] cooldown;
    logic [7:0]  max_restarts;
    logic [15:0] window;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now;
    logic        svc;
    logic        port;
    logic        prop;
    logic        half_hit;
    logic        live_nz;
    logic [31:0] now_plus_cd;
    logic [31:0] now_plus_win;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        acted;
    logic [2:0]  status;
    logic        fault;
    logic        success;
    logic [7:0]  restarts;
    logic [31:0] total;
    logic [15:0] cool_left;
  } res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== rtl/rsrl_front.sv =====
// Front end: accepts health checks, classifies them and holds them in a
// two-entry command queue. Depends on rsrl_pkg.
module rsrl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        in_now_seconds,
  input  logic               in_service_running,
  input  logic               in_port_listening,
  input  logic               in_port_setting_ok,
  input  logic [15:0]        in_half_closed_count,
  input  logic [15:0]        in_live_sessions,
  input  rsrl_pkg::cfg_t     cfg,
  output logic               cmd_valid,
  output rsrl_pkg::cmd_t     cmd,
  input  logic               cmd_take
);
  import rsrl_pkg::*;

  cmd_t       item;
  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;

  always_comb begin
    item.now          = in_now_seconds;
    item.svc          = in_service_running;
    item.port         = in_port_listening;
    item.prop         = in_port_setting_ok;
    item.half_hit     = in_half_closed_count >= cfg.threshold;
    item.live_nz      = |in_live_sessions;
    item.now_plus_cd  = sat_add(in_now_seconds, cfg.cooldown);
    item.now_plus_win = sat_add(in_now_seconds, cfg.window);
  end

  assign full      = cnt_r == 2'd2;
  assign push_ok   = push && !full;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];

  assign wp_nxt  = push_ok ? ~wp_r : wp_r;
  assign rp_nxt  = cmd_take ? ~rp_r : rp_r;
  assign cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, cmd_take};

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_take_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cnt_r != 2'd0) else $error("command taken from an empty queue");

endmodule

// ===== rtl/rsrl_back.sv =====
// Back end: supervisor state, one decision per cycle unless the result stage and result
// queue are both full, a result stage and a two-entry result queue. Depends on rsrl_pkg.
module rsrl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rsrl_pkg::cfg_t     cfg,
  input  logic               cmd_valid,
  input  rsrl_pkg::cmd_t     cmd,
  output logic               cmd_take,
  output logic               empty,
  input  logic               pop,
  output rsrl_pkg::res_t     res
);
  import rsrl_pkg::*;

  logic [31:0] wb_r, wb_nxt;
  logic [7:0]  wr_r, wr_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic        vp_r, vp_nxt;
  logic        cool_r, cool_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [31:0] fb_r, fb_nxt;
  logic [2:0]  lac_r, lac_nxt;

  logic [32:0] fdiff, wdiff;
  logic        fault_hit, win_exp;
  logic [31:0] wb_win, rl_dl;
  logic        fault_c, succ_c, healthy, core;
  logic [2:0]  act_c, want, want_st;
  res_t        res_c;

  logic        sv_r, sv_nxt;
  res_t        s_r;
  logic [31:0] sdl_r, snow_r;
  logic [31:0] dd;
  logic [15:0] left;
  logic        s_move;
  res_t        s_out;

  res_t        rq_r [2];
  logic        rq_wp_r, rq_rp_r;
  logic [1:0]  rq_cnt_r, rq_cnt_nxt;
  logic        rq_full, pop_ok;

  assign fdiff     = {1'b0, cmd.now} - {1'b0, fb_r};
  assign fault_hit = !fdiff[32] && (fdiff[31:0] >= {16'b0, cfg.hold});
  assign wdiff     = {1'b0, cmd.now} - {1'b0, wb_r};
  assign win_exp   = !wdiff[32] && (wdiff[31:0] >= {16'b0, cfg.window});
  assign wb_win    = sat_add(wb_r, cfg.window);

  always_comb begin
    if (win_exp) begin
      rl_dl = (cmd.now == 32'd0) ? cmd.now : cmd.now_plus_win;
    end else if (wb_r == 32'd0) begin
      rl_dl = cmd.now;
    end else if (cmd.now < wb_r) begin
      rl_dl = cmd.now_plus_win;
    end else begin
      rl_dl = wb_win;
    end
  end

  always_comb begin
    wb_nxt   = wb_r;
    wr_nxt   = wr_r;
    tot_nxt  = tot_r;
    vp_nxt   = vp_r;
    cool_nxt = cool_r;
    dl_nxt   = dl_r;
    fb_nxt   = fb_r;
    lac_nxt  = lac_r;
    fault_c  = 1'b0;
    succ_c   = 1'b0;
    act_c    = ACT_NONE;
    want     = ACT_NONE;
    healthy  = 1'b0;
    core     = cmd.svc && cmd.port;

    if (cmd.half_hit) begin
      if (fb_r == 32'd0) begin
        fb_nxt = cmd.now;
      end else if (fault_hit) begin
        fault_c = 1'b1;
      end
    end else begin
      fb_nxt = 32'd0;
    end

    if (win_exp) begin
      wb_nxt = cmd.now;
      wr_nxt = 8'd0;
      if (lac_nxt == ST_RATELIMIT) begin
        lac_nxt = ST_NONE;
        dl_nxt  = 32'd0;
      end
    end

    if (cool_nxt && (cmd.now >= dl_nxt)) begin
      cool_nxt = 1'b0;
      dl_nxt   = 32'd0;
      if (lac_nxt == ST_COOLDOWN) begin
        lac_nxt = ST_NONE;
      end
    end

    if (!cfg.enable) begin
      if (!cool_nxt && lac_nxt != ST_RATELIMIT) begin
        lac_nxt = ST_NONE;
      end
    end else if (core && cmd.live_nz) begin
      if (!cmd.prop) begin
        act_c = ACT_SOFTFIX;
      end
      fb_nxt  = 32'd0;
      healthy = 1'b1;
    end else if (core && cmd.prop && !fault_c) begin
      healthy = 1'b1;
    end else if (core) begin
      if (cool_nxt) begin
        lac_nxt = ST_COOLDOWN;
      end else if (!cmd.prop) begin
        want = ACT_FIXPORT;
      end else begin
        want = ACT_FAULT;
      end
    end else if (cool_nxt) begin
      lac_nxt = ST_COOLDOWN;
    end else if (!cmd.svc) begin
      want = ACT_START;
    end else begin
      want = ACT_RESTART;
    end

    if (healthy) begin
      cool_nxt = 1'b0;
      dl_nxt   = 32'd0;
      if (vp_nxt) begin
        lac_nxt = ST_SUCCESS;
        vp_nxt  = 1'b0;
        succ_c  = 1'b1;
      end else if (lac_nxt != ST_RATELIMIT && lac_nxt != ST_SUCCESS) begin
        lac_nxt = ST_NONE;
      end
    end

    unique case (want)
      ACT_START:   want_st = ST_START;
      ACT_RESTART: want_st = ST_RESTART;
      ACT_FIXPORT: want_st = ST_FIXPORT;
      ACT_FAULT:   want_st = ST_FIXFAULT;
      default:     want_st = ST_NONE;
    endcase

    if (want != ACT_NONE) begin
      if (wr_nxt >= cfg.max_restarts) begin
        dl_nxt  = rl_dl;
        lac_nxt = ST_RATELIMIT;
      end else begin
        act_c    = want;
        lac_nxt  = want_st;
        if (want == ACT_FAULT) begin
          fb_nxt = 32'd0;
        end
        wr_nxt   = wr_nxt + 8'd1;
        tot_nxt  = tot_r + 32'd1;
        vp_nxt   = 1'b1;
        cool_nxt = 1'b1;
        dl_nxt   = cmd.now_plus_cd;
      end
    end

    res_c.action    = act_c;
    res_c.acted     = (act_c != ACT_NONE) && (act_c != ACT_SOFTFIX);
    res_c.status    = lac_nxt;
    res_c.fault     = fault_c;
    res_c.success   = succ_c;
    res_c.restarts  = wr_nxt;
    res_c.total     = tot_nxt;
    res_c.cool_left = 16'd0;
  end

  assign rq_full  = rq_cnt_r == 2'd2;
  assign s_move   = sv_r && !rq_full;
  assign cmd_take = cmd_valid && (!sv_r || !rq_full);
  assign sv_nxt   = cmd_take ? 1'b1 : (s_move ? 1'b0 : sv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r   <= 32'd0;
      wr_r   <= 8'd0;
      tot_r  <= 32'd0;
      vp_r   <= 1'b0;
      cool_r <= 1'b0;
      dl_r   <= 32'd0;
      fb_r   <= 32'd0;
      lac_r  <= ST_NONE;
      sv_r   <= 1'b0;
    end else begin
      if (cmd_take) begin
        wb_r   <= wb_nxt;
        wr_r   <= wr_nxt;
        tot_r  <= tot_nxt;
        vp_r   <= vp_nxt;
        cool_r <= cool_nxt;
        dl_r   <= dl_nxt;
        fb_r   <= fb_nxt;
        lac_r  <= lac_nxt;
      end
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s_r    <= res_c;
      sdl_r  <= dl_nxt;
      snow_r <= cmd.now;
    end
  end

  assign dd = sdl_r - snow_r;

  always_comb begin
    if ((sdl_r != 32'd0) && (snow_r < sdl_r)) begin
      left = (|dd[31:16]) ? 16'hFFFF : dd[15:0];
    end else begin
      left = 16'd0;
    end
    s_out           = s_r;
    s_out.cool_left = left;
  end

  assign pop_ok     = pop && !empty;
  assign empty      = rq_cnt_r == 2'd0;
  assign res        = rq_r[rq_rp_r];
  assign rq_cnt_nxt = rq_cnt_r + {1'b0, s_move} - {1'b0, pop_ok};

  always_ff @(posedge clk) begin
    if (s_move) begin
      rq_r[rq_wp_r] <= s_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r  <= 1'b0;
      rq_rp_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      rq_wp_r  <= s_move ? ~rq_wp_r : rq_wp_r;
      rq_rp_r  <= pop_ok ? ~rq_rp_r : rq_rp_r;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  a_cool_has_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    cool_r |-> dl_r != 32'd0) else $error("cooling without a deadline");

  a_act_sets_verify: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_take && res_c.acted) |=> (vp_r && cool_r))
    else $error("recovery action did not arm verify and cooldown");

  a_acted_status: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r && s_r.acted) |-> (s_r.status == ST_START || s_r.status == ST_RESTART ||
                             s_r.status == ST_FIXPORT || s_r.status == ST_FIXFAULT))
    else $error("counted action with a non-action status");

  a_success_status: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r && s_r.success) |-> (s_r.status == ST_SUCCESS && !s_r.acted))
    else $error("success event with wrong status");

endmodule

// ===== rtl/restart_supervisor_with_rate_limit_core.sv =====
// Top level of the restart supervisor: configuration registers, front end and back end.
// Depends on rsrl_pkg, rsrl_front and rsrl_back.
//
// Takes one health check per clock cycle while full is low and returns one result beat per
// check, in order. A check is classified in the front end and queued; the back end updates
// the supervisor state for one check at a time, which is what fixes the rate at one beat per
// cycle while the result queue does not back up. A result passes from the result stage into
// a two-entry queue and waits there until popped. The user must write registers through
// cfg_wr_en, cfg_index and cfg_data only while the block is idle; the block does not enforce
// it. A value of zero in any register but the enable selects that register's default.
module restart_supervisor_with_rate_limit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_now_seconds,
  input  logic        in_service_running,
  input  logic        in_port_listening,
  input  logic        in_port_setting_ok,
  input  logic [15:0] in_half_closed_count,
  input  logic [15:0] in_live_sessions,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_action,
  output logic        out_acted,
  output logic [2:0]  out_last_status,
  output logic        out_fault_held,
  output logic        out_success_event,
  output logic [7:0]  out_restarts_in_window,
  output logic [31:0] out_total_recoveries,
  output logic [15:0] out_cooldown_left,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rsrl_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cmd_valid, cmd_take;
  cmd_t cmd;
  res_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLE:    cfg_nxt.enable       = cfg_data[0];
        CFG_THRESHOLD: cfg_nxt.threshold    = (cfg_data == 16'd0) ? DFLT_THRESHOLD : cfg_data;
        CFG_HOLD:      cfg_nxt.hold         = (cfg_data == 16'd0) ? DFLT_HOLD : cfg_data;
        CFG_COOLDOWN:  cfg_nxt.cooldown     = (cfg_data == 16'd0) ? DFLT_COOLDOWN : cfg_data;
        CFG_MAX:       cfg_nxt.max_restarts = (cfg_data[7:0] == 8'd0) ? DFLT_MAX
                                                                      : cfg_data[7:0];
        CFG_WINDOW:    cfg_nxt.window       = (cfg_data == 16'd0) ? DFLT_WINDOW : cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b1;
      cfg_r.threshold    <= DFLT_THRESHOLD;
      cfg_r.hold         <= DFLT_HOLD;
      cfg_r.cooldown     <= DFLT_COOLDOWN;
      cfg_r.max_restarts <= DFLT_MAX;
      cfg_r.window       <= DFLT_WINDOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsrl_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_now_seconds       (in_now_seconds),
    .in_service_running   (in_service_running),
    .in_port_listening    (in_port_listening),
    .in_port_setting_ok   (in_port_setting_ok),
    .in_half_closed_count (in_half_closed_count),
    .in_live_sessions     (in_live_sessions),
    .cfg                  (cfg_r),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_take             (cmd_take)
  );

  rsrl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_action             = res.action;
  assign out_acted              = res.acted;
  assign out_last_status        = res.status;
  assign out_fault_held         = res.fault;
  assign out_success_event      = res.success;
  assign out_restarts_in_window = res.restarts;
  assign out_total_recoveries   = res.total;
  assign out_cooldown_left      = res.cool_left;

endmodule
